[src/hsv_pkg.sv]
`default_nettype none
package hsv_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int FW          = FRAC_BITS + 1;
  localparam int HUE_W       = 14;
  localparam int SV_W        = 12;
  localparam int HUE_CW      = HUE_W - 1;
  localparam int SV_CW       = SV_W - 1;
  localparam int REM_W       = 10;
  localparam int COMP_W      = 8;

  localparam int HUE_MAX     = 5760;
  localparam int SV_MAX      = 1600;
  localparam int SECTOR_SPAN = 960;
  localparam int COMP_SCALE  = 255;

  // reciprocal multipliers, exact over the clamped input ranges
  localparam int RECIP_SHIFT = 24;
  localparam int SV_RECIP_W  = RECIP_SHIFT + FRAC_BITS - 10;
  localparam int SEC_RECIP_W = RECIP_SHIFT + FRAC_BITS - 9;
  localparam logic [63:0] SV_RECIP =
    ((64'd1 << (RECIP_SHIFT + FRAC_BITS)) + 64'(SV_MAX) - 64'd1) / 64'(SV_MAX);
  localparam logic [63:0] SEC_RECIP =
    ((64'd1 << (RECIP_SHIFT + FRAC_BITS)) + 64'(SECTOR_SPAN) - 64'd1) / 64'(SECTOR_SPAN);

  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    SECT_RY,
    SECT_YG,
    SECT_GC,
    SECT_CB,
    SECT_BM,
    SECT_MR
  } sector_t;

  typedef struct packed {
    logic             valid;
    sector_t          sector;
    logic [REM_W-1:0] rem;
    logic [SV_CW-1:0] sat;
    logic [SV_CW-1:0] val;
  } clamp_t;

  typedef struct packed {
    logic          valid;
    sector_t       sector;
    logic [FW-1:0] s;
    logic [FW-1:0] v;
    logic [FW-1:0] f;
  } frac_t;

  typedef struct packed {
    logic          valid;
    sector_t       sector;
    logic [FW-1:0] v;
    logic [FW-1:0] p;
    logic [FW-1:0] fs;
    logic [FW-1:0] gs;
  } prod_t;

  typedef struct packed {
    logic          valid;
    sector_t       sector;
    logic [FW-1:0] v;
    logic [FW-1:0] p;
    logic [FW-1:0] q;
    logic [FW-1:0] t;
  } comp_t;

endpackage
`default_nettype wire

[src/hsv_clamp.sv]
`default_nettype none
module hsv_clamp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire logic [hsv_pkg::HUE_W-1:0]  hue,
  input  wire logic [hsv_pkg::SV_W-1:0]   saturation,
  input  wire logic [hsv_pkg::SV_W-1:0]   brightness,
  output hsv_pkg::clamp_t                 out
);
  import hsv_pkg::*;

  logic [HUE_CW-1:0] hue_c;
  logic [SV_CW-1:0]  sat_c;
  logic [SV_CW-1:0]  val_c;
  logic [HUE_CW-1:0] base;
  sector_t           sector;

  always_comb begin
    if (hue[HUE_W-1]) begin
      hue_c = '0;
    end else if (hue[HUE_CW-1:0] > HUE_CW'(HUE_MAX)) begin
      hue_c = HUE_CW'(HUE_MAX);
    end else begin
      hue_c = hue[HUE_CW-1:0];
    end
    if (saturation[SV_W-1]) begin
      sat_c = '0;
    end else if (saturation[SV_CW-1:0] > SV_CW'(SV_MAX)) begin
      sat_c = SV_CW'(SV_MAX);
    end else begin
      sat_c = saturation[SV_CW-1:0];
    end
    if (brightness[SV_W-1]) begin
      val_c = '0;
    end else if (brightness[SV_CW-1:0] > SV_CW'(SV_MAX)) begin
      val_c = SV_CW'(SV_MAX);
    end else begin
      val_c = brightness[SV_CW-1:0];
    end
  end

  // full circle wraps to the first sector with zero remainder
  always_comb begin
    if (hue_c >= HUE_CW'(HUE_MAX)) begin
      sector = SECT_RY;
      base   = HUE_CW'(HUE_MAX);
    end else if (hue_c >= HUE_CW'(5 * SECTOR_SPAN)) begin
      sector = SECT_MR;
      base   = HUE_CW'(5 * SECTOR_SPAN);
    end else if (hue_c >= HUE_CW'(4 * SECTOR_SPAN)) begin
      sector = SECT_BM;
      base   = HUE_CW'(4 * SECTOR_SPAN);
    end else if (hue_c >= HUE_CW'(3 * SECTOR_SPAN)) begin
      sector = SECT_CB;
      base   = HUE_CW'(3 * SECTOR_SPAN);
    end else if (hue_c >= HUE_CW'(2 * SECTOR_SPAN)) begin
      sector = SECT_GC;
      base   = HUE_CW'(2 * SECTOR_SPAN);
    end else if (hue_c >= HUE_CW'(SECTOR_SPAN)) begin
      sector = SECT_YG;
      base   = HUE_CW'(SECTOR_SPAN);
    end else begin
      sector = SECT_RY;
      base   = '0;
    end
  end

  logic [HUE_CW-1:0] rem_full;
  assign rem_full = hue_c - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= load;
    end
    out.sector <= sector;
    out.rem    <= rem_full[REM_W-1:0];
    out.sat    <= sat_c;
    out.val    <= val_c;
  end

endmodule
`default_nettype wire

[src/hsv_scale.sv]
`default_nettype none
module hsv_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hsv_pkg::clamp_t in,
  output hsv_pkg::frac_t       out
);
  import hsv_pkg::*;

  localparam int PW = RECIP_SHIFT + FW;

  logic [PW-1:0] s_prod;
  logic [PW-1:0] v_prod;
  logic [PW-1:0] f_prod;

  assign s_prod = PW'(in.sat) * PW'(SV_RECIP[SV_RECIP_W-1:0]);
  assign v_prod = PW'(in.val) * PW'(SV_RECIP[SV_RECIP_W-1:0]);
  assign f_prod = PW'(in.rem) * PW'(SEC_RECIP[SEC_RECIP_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
    out.sector <= in.sector;
    out.s      <= s_prod[RECIP_SHIFT +: FW];
    out.v      <= v_prod[RECIP_SHIFT +: FW];
    out.f      <= f_prod[RECIP_SHIFT +: FW];
  end

endmodule
`default_nettype wire

[src/hsv_mix.sv]
`default_nettype none
module hsv_mix (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hsv_pkg::frac_t in,
  output hsv_pkg::comp_t      out
);
  import hsv_pkg::*;

  localparam int MW = 2 * FW;

  prod_t         mid;
  logic [MW-1:0] p_prod;
  logic [MW-1:0] fs_prod;
  logic [MW-1:0] gs_prod;
  logic [MW-1:0] q_prod;
  logic [MW-1:0] t_prod;

  assign p_prod  = MW'(in.v) * MW'(ONE - in.s);
  assign fs_prod = MW'(in.f) * MW'(in.s);
  assign gs_prod = MW'(ONE - in.f) * MW'(in.s);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else begin
      mid.valid <= in.valid;
    end
    mid.sector <= in.sector;
    mid.v      <= in.v;
    mid.p      <= p_prod[FRAC_BITS +: FW];
    mid.fs     <= fs_prod[FRAC_BITS +: FW];
    mid.gs     <= gs_prod[FRAC_BITS +: FW];
  end

  assign q_prod = MW'(mid.v) * MW'(ONE - mid.fs);
  assign t_prod = MW'(mid.v) * MW'(ONE - mid.gs);

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= mid.valid;
    end
    out.sector <= mid.sector;
    out.v      <= mid.v;
    out.p      <= mid.p;
    out.q      <= q_prod[FRAC_BITS +: FW];
    out.t      <= t_prod[FRAC_BITS +: FW];
  end

endmodule
`default_nettype wire

[src/hsv_order.sv]
`default_nettype none
module hsv_order (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire hsv_pkg::comp_t               in,
  output logic                              strobe,
  output logic [hsv_pkg::COMP_W-1:0]        red,
  output logic [hsv_pkg::COMP_W-1:0]        green,
  output logic [hsv_pkg::COMP_W-1:0]        blue
);
  import hsv_pkg::*;

  localparam int BW = FW + COMP_W;

  logic [FW-1:0] r_x;
  logic [FW-1:0] g_x;
  logic [FW-1:0] b_x;
  logic [BW-1:0] r_b;
  logic [BW-1:0] g_b;
  logic [BW-1:0] b_b;

  always_comb begin
    case (in.sector)
      SECT_RY: begin r_x = in.v; g_x = in.t; b_x = in.p; end
      SECT_YG: begin r_x = in.q; g_x = in.v; b_x = in.p; end
      SECT_GC: begin r_x = in.p; g_x = in.v; b_x = in.t; end
      SECT_CB: begin r_x = in.p; g_x = in.q; b_x = in.v; end
      SECT_BM: begin r_x = in.t; g_x = in.p; b_x = in.v; end
      default: begin r_x = in.v; g_x = in.p; b_x = in.q; end
    endcase
  end

  assign r_b = BW'(r_x) * BW'(COMP_SCALE);
  assign g_b = BW'(g_x) * BW'(COMP_SCALE);
  assign b_b = BW'(b_x) * BW'(COMP_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= in.valid;
    end
    red   <= r_b[FRAC_BITS +: COMP_W];
    green <= g_b[FRAC_BITS +: COMP_W];
    blue  <= b_b[FRAC_BITS +: COMP_W];
  end

endmodule
`default_nettype wire

[src/hsv_to_rgb_converter_unit.sv]
`default_nettype none
// HSV to RGB colour converter.
// Command channel: a colour (hue, saturation, brightness, signed, 1/16 degree
// and 1/16 percent) transfers at a rising edge with start high and busy low.
// busy is held low: a new colour may transfer on every cycle.
// Result channel: red, green and blue are shown for exactly one cycle with
// strobe high; the receiver takes them at the edge that ends that cycle.
// A taken colour passes the clamp, scale, two mix and order registers
// before it appears with strobe. Throughput: one colour per cycle.
// Stages: clamp and sector split, reciprocal scaling of s, v and f,
// two multiplier stages for p, q and t, then component ordering and
// scaling to eight bits; each stage after the clamp holds one multiply per path.
// Reset clears the valid bits of every stage; colours in flight are
// dropped and no strobe follows. The receiver cannot stall, so nothing
// is ever held back.
module hsv_to_rgb_converter_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [hsv_pkg::HUE_W-1:0]   hue,
  input  wire logic [hsv_pkg::SV_W-1:0]    saturation,
  input  wire logic [hsv_pkg::SV_W-1:0]    brightness,
  output logic                             strobe,
  output logic [hsv_pkg::COMP_W-1:0]       red,
  output logic [hsv_pkg::COMP_W-1:0]       green,
  output logic [hsv_pkg::COMP_W-1:0]       blue
);
  import hsv_pkg::*;

  clamp_t st_clamp;
  frac_t  st_frac;
  comp_t  st_comp;

  assign busy = 1'b0;

  hsv_clamp u_clamp (
    .clk        (clk),
    .rst        (rst),
    .load       (start && !busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out        (st_clamp)
  );

  hsv_scale u_scale (
    .clk (clk),
    .rst (rst),
    .in  (st_clamp),
    .out (st_frac)
  );

  hsv_mix u_mix (
    .clk (clk),
    .rst (rst),
    .in  (st_frac),
    .out (st_comp)
  );

  hsv_order u_order (
    .clk    (clk),
    .rst    (rst),
    .in     (st_comp),
    .strobe (strobe),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

endmodule
`default_nettype wire

[src/hsv_checker.sv]
`default_nettype none
module hsv_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [hsv_pkg::HUE_W-1:0]  hue,
  input wire logic [hsv_pkg::SV_W-1:0]   saturation,
  input wire logic [hsv_pkg::SV_W-1:0]   brightness,
  input wire logic                       strobe,
  input wire logic [hsv_pkg::COMP_W-1:0] red,
  input wire logic [hsv_pkg::COMP_W-1:0] green,
  input wire logic [hsv_pkg::COMP_W-1:0] blue
);
  import hsv_pkg::*;

  a_transfer_gives_result: assert property (
    @(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 strobe
  ) else $error("transfer not followed by a result after five cycles");

  a_result_has_transfer: assert property (
    @(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, 5)
  ) else $error("result without a matching transfer");

  a_grey_when_unsaturated: assert property (
    @(posedge clk) disable iff (rst)
    (strobe && $past(saturation[SV_W-1] || (saturation == '0), 5))
      |-> (red == green) && (green == blue)
  ) else $error("zero saturation gave a coloured result");

  a_black_when_dark: assert property (
    @(posedge clk) disable iff (rst)
    (strobe && $past(brightness[SV_W-1] || (brightness == '0), 5))
      |-> (red == '0) && (green == '0) && (blue == '0)
  ) else $error("zero brightness gave a non-black result");

  a_hue_unused: assert property (
    @(posedge clk) disable iff (rst)
    (strobe && $past(hue[HUE_W-1], 5) && $past(!saturation[SV_W-1], 5)
      && $past(saturation[SV_W-2:0] >= (SV_W-1)'(SV_MAX), 5))
      |-> (blue == '0)
  ) else $error("negative hue at full saturation gave non-zero blue");

endmodule

bind hsv_to_rgb_converter_unit hsv_checker u_checker (.*);
`default_nettype wire
